### design/wsip_pkg.sv
// Shared types, constants and the control program of the wheel speed PI block.
// No dependencies; used by the sequencer, the datapath and the top level.
package wsip_pkg;

  // field widths
  localparam int CountW  = 16;
  localparam int TargetW = 24;
  localparam int GainW   = 16;
  localparam int DscW    = 24;
  localparam int SpeedW  = 32;
  localparam int ErrW    = 33;
  localparam int DeltaW  = 34;
  localparam int ProdW   = 52;
  localparam int IncW    = 51;
  localparam int RndW    = 43;
  localparam int DriveW  = 24;
  localparam int DutyW   = 23;
  localparam int DistW   = 48;
  localparam int OutDataW = 128;
  localparam int PcW     = 4;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;

  // drive saturation, 99 percent in Q.16
  localparam logic signed [DriveW-1:0] DRIVE_LIMIT = 24'sd6488064;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_TARGET    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_INT_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_SC  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIST_SC   = 3'd4;

  // multiplier operand selects
  localparam logic [1:0] A_COUNT = 2'd0;
  localparam logic [1:0] A_INT   = 2'd1;
  localparam logic [1:0] A_PROP  = 2'd2;
  localparam logic [1:0] B_SPEEDSC = 2'd0;
  localparam logic [1:0] B_DISTSC  = 2'd1;
  localparam logic [1:0] B_ERR     = 2'd2;
  localparam logic [1:0] B_DELTA   = 2'd3;

  // datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LD_SPEED = 4'd1;
  localparam logic [3:0] OP_DIST_ERR = 4'd2;
  localparam logic [3:0] OP_DELTA    = 4'd3;
  localparam logic [3:0] OP_INC_LD   = 4'd4;
  localparam logic [3:0] OP_INC_ADD  = 4'd5;
  localparam logic [3:0] OP_ROUND    = 4'd6;
  localparam logic [3:0] OP_DRIVE    = 4'd7;
  localparam logic [3:0] OP_EMIT     = 4'd8;

  // sequencing
  localparam logic [1:0] SQ_NEXT     = 2'd0;
  localparam logic [1:0] SQ_WAIT_IN  = 2'd1;
  localparam logic [1:0] SQ_WAIT_OUT = 2'd2;

  typedef struct packed {
    logic [1:0] a_sel;
    logic [1:0] b_sel;
    logic       mul_en;
    logic [3:0] op;
    logic [1:0] seq;
  } ctl_t;

  typedef struct packed {
    logic [TargetW-1:0] target_speed;
    logic [GainW-1:0]   prop_gain;
    logic [GainW-1:0]   int_gain;
    logic [GainW-1:0]   speed_scale;
    logic [DscW-1:0]    distance_scale;
  } cfg_regs_t;

  function automatic ctl_t mk(input logic [1:0] a, input logic [1:0] b, input logic m,
                              input logic [3:0] op, input logic [1:0] sq);
    ctl_t w;
    w.a_sel = a;
    w.b_sel = b;
    w.mul_en = m;
    w.op = op;
    w.seq = sq;
    return w;
  endfunction

  // control program, one word per step
  function automatic ctl_t rom(input logic [PcW-1:0] pc);
    ctl_t w;
    case (pc)
      4'd0: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_NOP,      SQ_WAIT_IN);
      4'd1: w = mk(A_COUNT, B_SPEEDSC, 1'b1, OP_NOP,      SQ_NEXT);
      4'd2: w = mk(A_COUNT, B_DISTSC,  1'b1, OP_LD_SPEED, SQ_NEXT);
      4'd3: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_DIST_ERR, SQ_NEXT);
      4'd4: w = mk(A_INT,   B_ERR,     1'b1, OP_DELTA,    SQ_NEXT);
      4'd5: w = mk(A_PROP,  B_DELTA,   1'b1, OP_INC_LD,   SQ_NEXT);
      4'd6: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_INC_ADD,  SQ_NEXT);
      4'd7: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_ROUND,    SQ_NEXT);
      4'd8: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_DRIVE,    SQ_NEXT);
      4'd9: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_EMIT,     SQ_WAIT_OUT);
      default: w = mk(A_COUNT, B_SPEEDSC, 1'b0, OP_NOP,   SQ_WAIT_OUT);
    endcase
    return w;
  endfunction

endpackage

### design/wheel_speed_incremental_pi_top.sv
// Top level of the incremental PI wheel speed controller.
// Depends on wsip_pkg, wsip_seq and wsip_datapath.
//
// Use: each input beat is one control tick. in_tdata carries the signed
// encoder count of the period, in_tuser the flag that clears the distance
// before this tick's increment. Each tick gives exactly one output beat with
// the forward and backward duties, the measured speed and the distance.
// The cfg_ channel writes the target speed, the two gains and the two
// scales; write them only while no tick is in flight. cfg_ready is always high.
// Sequencing: a short microprogram of ten steps runs per tick on one shared
// 17 x 35 multiplier (four products per tick), so a new tick is taken only
// after the previous tick has run through all of its steps.
// A result waits in the output register; the next tick is accepted and
// worked on meanwhile, and it is held in its last step only while the
// earlier result is still not taken.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// previous error, the drive accumulator and the distance, and empties the
// output register.
module wheel_speed_incremental_pi_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: [15:0] encoder_count
  input  logic [wsip_pkg::CountW-1:0]        in_tdata,
  // in_tuser: [0] clear_distance
  input  logic [0:0]                         in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: [22:0] forward_duty, [45:23] backward_duty,
  //            [77:46] measured_speed, [125:78] distance, [127:126] zero
  output logic [wsip_pkg::OutDataW-1:0]      out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsip_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [wsip_pkg::CfgDataW-1:0]      cfg_data
);

  wsip_pkg::ctl_t                        ctl;
  wsip_pkg::cfg_regs_t                   cfg_r;
  logic                                  idle;
  logic                                  in_fire;
  logic                                  out_free;
  logic                                  out_tvalid_r;
  logic [wsip_pkg::OutDataW-1:0]         out_tdata_r;
  logic signed [wsip_pkg::DriveW-1:0]    drive;
  logic signed [wsip_pkg::SpeedW-1:0]    speed;
  logic [wsip_pkg::DistW-1:0]            distance;
  logic [wsip_pkg::DriveW-1:0]           neg_drive;
  logic [wsip_pkg::DutyW-1:0]            fwd_duty;
  logic [wsip_pkg::DutyW-1:0]            bwd_duty;
  logic                                  emit;

  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_speed   <= 24'd65536;
      cfg_r.prop_gain      <= 16'd5120;
      cfg_r.int_gain       <= 16'd2560;
      cfg_r.speed_scale    <= 16'd2189;
      cfg_r.distance_scale <= 24'd2802;
    end else if (cfg_valid) begin
      case (cfg_index)
        wsip_pkg::REG_TARGET:    cfg_r.target_speed   <= cfg_data;
        wsip_pkg::REG_PROP_GAIN: cfg_r.prop_gain      <= cfg_data[15:0];
        wsip_pkg::REG_INT_GAIN:  cfg_r.int_gain       <= cfg_data[15:0];
        wsip_pkg::REG_SPEED_SC:  cfg_r.speed_scale    <= cfg_data[15:0];
        wsip_pkg::REG_DIST_SC:   cfg_r.distance_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  wsip_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctl      (ctl),
    .idle     (idle)
  );

  wsip_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .cfg            (cfg_r),
    .ld_in          (in_fire),
    .encoder_count  ($signed(in_tdata)),
    .clear_distance (in_tuser[0]),
    .drive          (drive),
    .speed          (speed),
    .distance       (distance)
  );

  // split the drive into the two duties
  assign neg_drive = -drive;
  assign fwd_duty  = drive[23] ? '0 : drive[22:0];
  assign bwd_duty  = drive[23] ? neg_drive[22:0] : '0;
  assign emit      = (ctl.op == wsip_pkg::OP_EMIT) && out_free;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_tdata_r <= {2'b00, distance, speed, bwd_duty, fwd_duty};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  a_one_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22:0] == '0 || out_tdata[45:23] == '0))
    else $error("both duties non-zero");

  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (drive <= wsip_pkg::DRIVE_LIMIT) && (drive >= -wsip_pkg::DRIVE_LIMIT))
    else $error("drive accumulator beyond limit");

  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second tick accepted while busy");

endmodule

### design/wsip_seq.sv
// Step counter and control store of the wheel speed PI block.
// Depends on wsip_pkg for the control word and the program.
module wsip_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  output wsip_pkg::ctl_t      ctl,
  output logic                idle
);

  logic [wsip_pkg::PcW-1:0] pc_r;
  logic [wsip_pkg::PcW-1:0] pc_nxt;

  assign ctl  = wsip_pkg::rom(pc_r);
  assign idle = (ctl.seq == wsip_pkg::SQ_WAIT_IN);

  // next step: advance, hold on a wait, restart after the result is handed over
  always_comb begin
    pc_nxt = pc_r;
    case (ctl.seq)
      wsip_pkg::SQ_NEXT:     pc_nxt = pc_r + 4'd1;
      wsip_pkg::SQ_WAIT_IN:  if (in_fire) pc_nxt = pc_r + 4'd1;
      wsip_pkg::SQ_WAIT_OUT: if (out_free) pc_nxt = '0;
      default:               pc_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

### design/wsip_datapath.sv
// Datapath of the wheel speed PI block: one shared multiplier and working registers.
// Depends on wsip_pkg; driven by the control word from wsip_seq.
module wsip_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wsip_pkg::ctl_t                        ctl,
  input  wsip_pkg::cfg_regs_t                   cfg,
  input  logic                                  ld_in,
  input  logic signed [wsip_pkg::CountW-1:0]    encoder_count,
  input  logic                                  clear_distance,
  output logic signed [wsip_pkg::DriveW-1:0]    drive,
  output logic signed [wsip_pkg::SpeedW-1:0]    speed,
  output logic [wsip_pkg::DistW-1:0]            distance
);

  logic signed [wsip_pkg::CountW-1:0]  count_r;
  logic                                clear_r;
  logic signed [wsip_pkg::ProdW-1:0]   prod_r;
  logic signed [wsip_pkg::SpeedW-1:0]  speed_r;
  logic signed [wsip_pkg::ErrW-1:0]    err_r;
  logic signed [wsip_pkg::DeltaW-1:0]  prev_r;
  logic signed [wsip_pkg::DeltaW-1:0]  dlt_r;
  logic signed [wsip_pkg::IncW-1:0]    inc_r;
  logic signed [wsip_pkg::RndW-1:0]    rnd_r;
  logic signed [wsip_pkg::DriveW-1:0]  acc_r;
  logic [wsip_pkg::DistW-1:0]          dist_r;

  logic signed [16:0]                  a_mux;
  logic signed [34:0]                  b_mux;
  logic signed [wsip_pkg::ProdW-1:0]   prod_full;
  logic [wsip_pkg::DistW-1:0]          dist_base;
  logic signed [wsip_pkg::ErrW-1:0]    err_nxt;
  logic signed [wsip_pkg::IncW-1:0]    rnd_sum;
  logic signed [43:0]                  drv_sum;
  logic signed [43:0]                  lim_pos;
  logic signed [43:0]                  lim_neg;
  logic signed [wsip_pkg::DriveW-1:0]  acc_nxt;

  // operand selection
  always_comb begin
    case (ctl.a_sel)
      wsip_pkg::A_INT:  a_mux = $signed({1'b0, cfg.int_gain});
      wsip_pkg::A_PROP: a_mux = $signed({1'b0, cfg.prop_gain});
      default:          a_mux = $signed({count_r[15], count_r});
    endcase
    case (ctl.b_sel)
      wsip_pkg::B_DISTSC: b_mux = $signed({11'b0, cfg.distance_scale});
      wsip_pkg::B_ERR:    b_mux = $signed({{2{err_r[32]}}, err_r});
      wsip_pkg::B_DELTA:  b_mux = $signed({dlt_r[33], dlt_r});
      default:            b_mux = $signed({19'b0, cfg.speed_scale});
    endcase
  end

  assign prod_full = a_mux * b_mux;

  // error, distance base, rounding and clamped drive
  assign err_nxt   = $signed({{9{cfg.target_speed[23]}}, cfg.target_speed})
                   - $signed({speed_r[31], speed_r});
  assign dist_base = clear_r ? '0 : dist_r;
  assign rnd_sum   = inc_r + 51'sd128;
  assign drv_sum   = $signed({{20{acc_r[23]}}, acc_r}) + $signed({rnd_r[42], rnd_r});
  assign lim_pos   = $signed({{20{wsip_pkg::DRIVE_LIMIT[23]}}, wsip_pkg::DRIVE_LIMIT});
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (drv_sum >= lim_pos) begin
      acc_nxt = wsip_pkg::DRIVE_LIMIT;
    end else if (drv_sum <= lim_neg) begin
      acc_nxt = -wsip_pkg::DRIVE_LIMIT;
    end else begin
      acc_nxt = drv_sum[23:0];
    end
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      acc_r  <= '0;
      dist_r <= '0;
    end else begin
      case (ctl.op)
        wsip_pkg::OP_DIST_ERR:
          dist_r <= dist_base + {{8{prod_r[39]}}, prod_r[39:0]};
        wsip_pkg::OP_DELTA:
          prev_r <= $signed({err_r[32], err_r});
        wsip_pkg::OP_DRIVE:
          acc_r <= acc_nxt;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ld_in) begin
      count_r <= encoder_count;
      clear_r <= clear_distance;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_full;
    end
    case (ctl.op)
      wsip_pkg::OP_LD_SPEED: speed_r <= prod_r[31:0];
      wsip_pkg::OP_DIST_ERR: err_r   <= err_nxt;
      wsip_pkg::OP_DELTA:    dlt_r   <= $signed({err_r[32], err_r}) - prev_r;
      wsip_pkg::OP_INC_LD:   inc_r   <= prod_r[50:0];
      wsip_pkg::OP_INC_ADD:  inc_r   <= inc_r + prod_r[50:0];
      wsip_pkg::OP_ROUND:    rnd_r   <= rnd_sum[50:8];
      default: ;
    endcase
  end

  assign drive    = acc_r;
  assign speed    = speed_r;
  assign distance = dist_r;

endmodule
